// ===== sv/pfc_pkg.sv =====
// Package with the format codes, register indexes, luma constants and payload types.
package pfc_pkg;

   // Pixel format codes, shared by the source and target registers.
   localparam logic [2:0] FMT_I8       = 3'd0;
   localparam logic [2:0] FMT_AI88     = 3'd1;
   localparam logic [2:0] FMT_RGB888   = 3'd2;
   localparam logic [2:0] FMT_RGBA8888 = 3'd3;
   localparam logic [2:0] FMT_A8       = 3'd4;
   localparam logic [2:0] FMT_RGB565   = 3'd5;
   localparam logic [2:0] FMT_RGBA4444 = 3'd6;
   localparam logic [2:0] FMT_RGB5A1   = 3'd7;

   // Source formats are the first four codes.
   localparam logic [1:0] SRC_I8       = 2'd0;
   localparam logic [1:0] SRC_AI88     = 2'd1;
   localparam logic [1:0] SRC_RGB888   = 2'd2;
   localparam logic [1:0] SRC_RGBA8888 = 2'd3;

   // Register indexes and widths.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_FORMAT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_FORMAT = 1'd1;
   localparam logic [1:0] SOURCE_FORMAT_RESET = SRC_RGBA8888;
   localparam logic [2:0] TARGET_FORMAT_RESET = FMT_RGBA8888;

   // Luma weights, rounding term and the reciprocal of 1000 in 2^-28 units.
   localparam logic [8:0]  LUMA_R_COEF = 9'd299;
   localparam logic [9:0]  LUMA_G_COEF = 10'd587;
   localparam logic [6:0]  LUMA_B_COEF = 7'd114;
   localparam logic [17:0] LUMA_ROUND  = 18'd500;
   localparam int unsigned LUMA_SHIFT  = 28;
   localparam logic [18:0] LUMA_RECIP  = 19'd268436;

   // Byte counts.
   localparam logic [2:0] BYTES_ONE   = 3'd1;
   localparam logic [2:0] BYTES_TWO   = 3'd2;
   localparam logic [2:0] BYTES_THREE = 3'd3;
   localparam logic [2:0] BYTES_FOUR  = 3'd4;

   // Request payload: one source pixel.
   typedef struct packed {
      logic [7:0] byte_zero;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
      logic       last_pixel;
   } req_payload_type;

   // Response payload: one converted pixel.
   typedef struct packed {
      logic [31:0] out_pixel;
      logic [2:0]  out_bytes;
      logic [2:0]  out_format;
      logic        last_out;
   } rsp_payload_type;

endpackage

// ===== sv/pfc_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
interface pfc_stream_if #(
   parameter type payload_type = pfc_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/pixel_format_converter.sv =====
// Top level of the pixel format converter: a four-stage conversion pipeline.
//
//   Channel   Direction  Carries
//   req       in         one source pixel (four bytes and an end-of-image flag)
//   rsp       out        one converted pixel, its byte count and format
//   csr_*     in         writes to the source and target format registers
//
// One request is accepted per cycle unless a stalled response has filled every stage.
// The depth is set by the luma path: weight multiply, sum, reciprocal
// multiply for the divide by 1000, then format packing into the output register.
// Reset is synchronous; it clears the stage valid bits and sets both format registers to RGBA8888.
// A stalled response holds each full stage that has only full stages after it; the others keep filling.
module pixel_format_converter (
   input  logic                                  clock,
   input  logic                                  reset,
   pfc_stream_if.sink                            req,
   pfc_stream_if.source                          rsp,
   input  logic                                  csr_we,
   input  logic [pfc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pfc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // Format registers.
   logic [1:0] source_format_ff;
   logic [2:0] target_format_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_format_ff <= pfc_pkg::SOURCE_FORMAT_RESET;
         target_format_ff <= pfc_pkg::TARGET_FORMAT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pfc_pkg::CSR_SOURCE_FORMAT: source_format_ff <= csr_wdata[1:0];
            pfc_pkg::CSR_TARGET_FORMAT: target_format_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage enables: a stage loads when it is empty or the next one loads.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en;

   assign s4_en     = !s4_valid_ff || rsp.ready;
   assign s3_en     = !s3_valid_ff || s4_en;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req.ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= req.valid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
         if (s4_en) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage one: capture the pixel and formats, multiply by the luma weights.
   pfc_pkg::req_payload_type s1_pix_ff, s2_pix_ff, s3_pix_ff;
   logic [1:0]  s1_src_ff, s2_src_ff, s3_src_ff;
   logic [2:0]  s1_dst_ff, s2_dst_ff, s3_dst_ff;
   logic [16:0] s1_prod_r_ff, s1_prod_r_in;
   logic [17:0] s1_prod_g_ff, s1_prod_g_in;
   logic [14:0] s1_prod_b_ff, s1_prod_b_in;

   assign s1_prod_r_in = {9'd0, req.payload.byte_zero} * {8'd0, pfc_pkg::LUMA_R_COEF};
   assign s1_prod_g_in = {10'd0, req.payload.byte_one} * {8'd0, pfc_pkg::LUMA_G_COEF};
   assign s1_prod_b_in = {7'd0, req.payload.byte_two} * {8'd0, pfc_pkg::LUMA_B_COEF};

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_pix_ff    <= req.payload;
         s1_src_ff    <= source_format_ff;
         s1_dst_ff    <= target_format_ff;
         s1_prod_r_ff <= s1_prod_r_in;
         s1_prod_g_ff <= s1_prod_g_in;
         s1_prod_b_ff <= s1_prod_b_in;
      end
   end

   // Stage two: add the weighted channels and the rounding term.
   logic [17:0] s2_sum_ff, s2_sum_in;

   assign s2_sum_in = {1'b0, s1_prod_r_ff} + s1_prod_g_ff + {3'd0, s1_prod_b_ff}
                      + pfc_pkg::LUMA_ROUND;

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_pix_ff <= s1_pix_ff;
         s2_src_ff <= s1_src_ff;
         s2_dst_ff <= s1_dst_ff;
         s2_sum_ff <= s2_sum_in;
      end
   end

   // Stage three: divide by 1000 through the scaled reciprocal.
   logic [36:0] s3_recip_prod;
   logic [7:0]  s3_luma_ff;

   assign s3_recip_prod = {19'd0, s2_sum_ff} * {18'd0, pfc_pkg::LUMA_RECIP};

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_pix_ff  <= s2_pix_ff;
         s3_src_ff  <= s2_src_ff;
         s3_dst_ff  <= s2_dst_ff;
         s3_luma_ff <= s3_recip_prod[pfc_pkg::LUMA_SHIFT +: 8];
      end
   end

   // Stage four: unpack into channels and pack the target format.
   logic [7:0] ch_r, ch_g, ch_b, ch_a, ch_i;
   logic       grey, pass;
   logic [2:0] src_fmt;
   pfc_pkg::rsp_payload_type rsp_ff, rsp_in;

   assign src_fmt = {1'b0, s3_src_ff};
   assign grey    = (s3_src_ff == pfc_pkg::SRC_I8) || (s3_src_ff == pfc_pkg::SRC_AI88);
   assign ch_r    = s3_pix_ff.byte_zero;
   assign ch_g    = grey ? s3_pix_ff.byte_zero : s3_pix_ff.byte_one;
   assign ch_b    = grey ? s3_pix_ff.byte_zero : s3_pix_ff.byte_two;
   assign ch_i    = grey ? s3_pix_ff.byte_zero : s3_luma_ff;
   assign pass    = (s3_dst_ff == src_fmt)
                    || ((s3_dst_ff == pfc_pkg::FMT_A8)
                        && ((s3_src_ff == pfc_pkg::SRC_I8)
                            || (s3_src_ff == pfc_pkg::SRC_RGB888)));

   always_comb begin
      unique case (s3_src_ff)
         pfc_pkg::SRC_AI88:     ch_a = s3_pix_ff.byte_one;
         pfc_pkg::SRC_RGBA8888: ch_a = s3_pix_ff.byte_three;
         default:               ch_a = 8'hFF;
      endcase
   end

   always_comb begin
      rsp_in.last_out = s3_pix_ff.last_pixel;
      if (pass) begin
         // Equal formats, or A8 from I8 or RGB888 (no alpha): repack the source bytes only.
         rsp_in.out_format = src_fmt;
         unique case (s3_src_ff)
            pfc_pkg::SRC_I8: begin
               rsp_in.out_pixel = {24'd0, s3_pix_ff.byte_zero};
               rsp_in.out_bytes = pfc_pkg::BYTES_ONE;
            end
            pfc_pkg::SRC_AI88: begin
               rsp_in.out_pixel = {16'd0, s3_pix_ff.byte_one, s3_pix_ff.byte_zero};
               rsp_in.out_bytes = pfc_pkg::BYTES_TWO;
            end
            pfc_pkg::SRC_RGB888: begin
               rsp_in.out_pixel = {8'd0, s3_pix_ff.byte_two, s3_pix_ff.byte_one,
                                   s3_pix_ff.byte_zero};
               rsp_in.out_bytes = pfc_pkg::BYTES_THREE;
            end
            default: begin
               rsp_in.out_pixel = {s3_pix_ff.byte_three, s3_pix_ff.byte_two,
                                   s3_pix_ff.byte_one, s3_pix_ff.byte_zero};
               rsp_in.out_bytes = pfc_pkg::BYTES_FOUR;
            end
         endcase
      end else begin
         rsp_in.out_format = s3_dst_ff;
         unique case (s3_dst_ff)
            pfc_pkg::FMT_I8: begin
               rsp_in.out_pixel = {24'd0, ch_i};
               rsp_in.out_bytes = pfc_pkg::BYTES_ONE;
            end
            pfc_pkg::FMT_AI88: begin
               rsp_in.out_pixel = {16'd0, ch_a, ch_i};
               rsp_in.out_bytes = pfc_pkg::BYTES_TWO;
            end
            pfc_pkg::FMT_RGB888: begin
               rsp_in.out_pixel = {8'd0, ch_b, ch_g, ch_r};
               rsp_in.out_bytes = pfc_pkg::BYTES_THREE;
            end
            pfc_pkg::FMT_RGBA8888: begin
               rsp_in.out_pixel = {ch_a, ch_b, ch_g, ch_r};
               rsp_in.out_bytes = pfc_pkg::BYTES_FOUR;
            end
            pfc_pkg::FMT_A8: begin
               rsp_in.out_pixel = {24'd0, ch_a};
               rsp_in.out_bytes = pfc_pkg::BYTES_ONE;
            end
            pfc_pkg::FMT_RGB565: begin
               rsp_in.out_pixel = {16'd0, ch_r[7:3], ch_g[7:2], ch_b[7:3]};
               rsp_in.out_bytes = pfc_pkg::BYTES_TWO;
            end
            pfc_pkg::FMT_RGBA4444: begin
               rsp_in.out_pixel = {16'd0, ch_r[7:4], ch_g[7:4], ch_b[7:4], ch_a[7:4]};
               rsp_in.out_bytes = pfc_pkg::BYTES_TWO;
            end
            default: begin
               rsp_in.out_pixel = {16'd0, ch_r[7:3], ch_g[7:3], ch_b[7:3], ch_a[7]};
               rsp_in.out_bytes = pfc_pkg::BYTES_TWO;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (s4_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid   = s4_valid_ff;
   assign rsp.payload = rsp_ff;

   // The pipeline only refuses a request when the response side is stalled.
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp.valid && !rsp.ready))
      else $error("request refused without a stalled response");

   // One-byte responses carry nothing above the low byte.
   a_one_byte_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.payload.out_bytes == pfc_pkg::BYTES_ONE))
         |-> (rsp.payload.out_pixel[31:8] == 24'd0))
      else $error("one-byte pixel has stray upper bits");

   // Three bytes only ever come from RGB888.
   a_three_byte_format: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.payload.out_bytes == pfc_pkg::BYTES_THREE))
         |-> (rsp.payload.out_format == pfc_pkg::FMT_RGB888))
      else $error("three-byte pixel with a format other than RGB888");

endmodule
